// ----- hdl/salnt_pkg.sv -----
// Shared types, constants and the level mapping for the sensor average and noise tracker.
// No dependencies.
package salnt_pkg;

	localparam int AVG_W   = 10;
	localparam int LEVEL_W = 4;

	localparam logic [AVG_W-1:0] DUST_STEP  = 10'd80;
	localparam logic [AVG_W-1:0] LIGHT_STEP = 10'd100;
	localparam int               LEVEL_TOP  = 10;

	typedef struct packed {
		logic [AVG_W-1:0] dust_sample;
		logic [AVG_W-1:0] light_sample;
		logic [AVG_W-1:0] noise_sample;
	} sample_t;

	typedef struct packed {
		logic [AVG_W-1:0]   dust_average;
		logic [LEVEL_W-1:0] dust_level;
		logic [AVG_W-1:0]   light_average;
		logic [LEVEL_W-1:0] light_level;
		logic [AVG_W-1:0]   noise_average;
		logic [LEVEL_W-1:0] noise_level;
		logic               noise_updated;
	} result_t;

	// Load enables of the two divider stages.
	typedef struct packed {
		logic adv_a;
		logic adv_b;
	} div_ctl_t;

	// min(avg/step + 1, 10) as a count of thresholds crossed.
	function automatic logic [LEVEL_W-1:0] level_of(logic [AVG_W-1:0] avg,
		logic [AVG_W-1:0] step);
		logic [LEVEL_W-1:0] lvl;
		int thr;
		lvl = LEVEL_W'(1);
		for (int k = 1; k < LEVEL_TOP; k++) begin
			thr = k * int'(step);
			if (int'(avg) >= thr) lvl = lvl + LEVEL_W'(1);
		end
		return lvl;
	endfunction

endpackage

// ----- hdl/salnt_recip_div.sv -----
// Two-stage divide of a running sum by a constant: reciprocal multiply, then one correction.
// Depends on salnt_pkg.
module salnt_recip_div #(
	parameter int SUM_W   = 16,
	parameter int DIVISOR = 50
) (
	input  logic                       clk,
	input  salnt_pkg::div_ctl_t        ctl,
	input  logic [SUM_W-1:0]           sum,
	output logic [salnt_pkg::AVG_W-1:0] quot
);
	import salnt_pkg::*;

	// floor(2^SUM_W / DIVISOR): estimate is exact or one low since sum < 2^SUM_W
	localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / DIVISOR);

	logic [2*SUM_W-1:0] prod;
	logic [SUM_W-1:0]   sum_a;
	logic [AVG_W-1:0]   qest_a;
	logic [SUM_W-1:0]   qw;
	logic [SUM_W-1:0]   rem;

	assign prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP);
	assign qw   = SUM_W'(qest_a) * SUM_W'(DIVISOR);
	assign rem  = sum_a - qw;

	always_ff @(posedge clk) begin
		if (ctl.adv_a) begin
			sum_a  <= sum;
			qest_a <= prod[SUM_W +: AVG_W];
		end
		if (ctl.adv_b) begin
			quot <= (rem >= SUM_W'(DIVISOR)) ? qest_a + AVG_W'(1) : qest_a;
		end
	end

endmodule

// ----- hdl/sensor_average_level_noise_tracker_core.sv -----
// Sensor average, level and noise tracker: boxcar averages of dust and light, peak-to-peak
// noise envelope. Depends on salnt_pkg and salnt_recip_div.
// Throughput: one sample per cycle while result_stall does not hold the pipeline, set by
// the sample ring memory, which reads the oldest entry and writes the newest at the same
// address in the same cycle (read-first); the peak ring works the same way at window close.
// Reset: sums, positions and per-entry valid bits clear at once; no clearing pass.
module sensor_average_level_noise_tracker_core #(
	parameter int SAMPLE_WINDOW = 50,
	parameter int PEAK_WINDOW   = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  salnt_pkg::sample_t  sample,
	output logic                result_valid,
	input  logic                result_stall,
	output salnt_pkg::result_t  result
);
	import salnt_pkg::*;

	localparam int POS_W  = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
	localparam int PK_W   = (PEAK_WINDOW > 1) ? $clog2(PEAK_WINDOW) : 1;
	localparam int SUM_W  = AVG_W + POS_W;
	localparam int PSUM_W = AVG_W + PK_W;

	// pipeline occupancy and load enables
	logic v1, v2, v3, v4, v5;
	logic ld1, ld2, ld3, ld4, ld5;
	logic accept;

	assign ld5 = !v5 || !result_stall;
	assign ld4 = !v4 || ld5;
	assign ld3 = !v3 || ld4;
	assign ld2 = !v2 || ld3;
	assign ld1 = !v1 || ld2;
	assign sample_stall = !ld1;
	assign accept = sample_valid && ld1;
	assign result_valid = v5;

	// position and window tracking
	logic [POS_W-1:0] pos_q;
	logic [PK_W-1:0]  pk_q;
	logic [AVG_W-1:0] wmax_q, wmin_q, wmax_n, wmin_n, pp_n;
	logic             close_n;

	always_comb begin
		if (pos_q == '0) begin
			wmax_n = sample.noise_sample;
			wmin_n = sample.noise_sample;
		end else begin
			wmax_n = (sample.noise_sample > wmax_q) ? sample.noise_sample : wmax_q;
			wmin_n = (sample.noise_sample < wmin_q) ? sample.noise_sample : wmin_q;
		end
		pp_n    = wmax_n - wmin_n;
		close_n = (pos_q == POS_W'(SAMPLE_WINDOW - 1));
	end

	// ring memories: entries not yet written read as zero through their valid bits
	logic [2*AVG_W-1:0]     ring_mem [SAMPLE_WINDOW];
	logic [AVG_W-1:0]       peak_mem [PEAK_WINDOW];
	logic [SAMPLE_WINDOW-1:0] ring_vld_q;
	logic [PEAK_WINDOW-1:0]   peak_vld_q;

	logic [2*AVG_W-1:0] ring_rd_s1;
	logic [AVG_W-1:0]   peak_rd_s1;
	logic               ring_vld_s1, peak_vld_s1;
	logic [AVG_W-1:0]   dust_s1, light_s1, pp_s1;
	logic               close_s1, close_s2, close_s3, close_s4;

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_rd_s1        <= ring_mem[pos_q];
			ring_mem[pos_q]   <= {sample.dust_sample, sample.light_sample};
			if (close_n) begin
				peak_rd_s1    <= peak_mem[pk_q];
				peak_mem[pk_q] <= pp_n;
			end
		end
	end

	// running sums, advanced as a transaction moves from stage 1 to stage 2
	logic [SUM_W-1:0]  dust_sum_q, light_sum_q, dust_sum_n, light_sum_n;
	logic [SUM_W-1:0]  dust_sum_s2, light_sum_s2;
	logic [PSUM_W-1:0] peak_sum_q, peak_sum_n, peak_sum_s2;
	logic [AVG_W-1:0]  dust_old, light_old, peak_old;
	logic              adv12;

	assign adv12     = v1 && ld2;
	assign dust_old  = ring_vld_s1 ? ring_rd_s1[AVG_W +: AVG_W] : '0;
	assign light_old = ring_vld_s1 ? ring_rd_s1[0 +: AVG_W] : '0;
	assign peak_old  = peak_vld_s1 ? peak_rd_s1 : '0;

	assign dust_sum_n  = dust_sum_q - SUM_W'(dust_old) + SUM_W'(dust_s1);
	assign light_sum_n = light_sum_q - SUM_W'(light_old) + SUM_W'(light_s1);
	assign peak_sum_n  = peak_sum_q - PSUM_W'(peak_old) + PSUM_W'(pp_s1);

	// divider stages
	div_ctl_t          div_ctl;
	logic [AVG_W-1:0]  dust_avg_s4, light_avg_s4, peak_avg_s4;

	assign div_ctl.adv_a = ld3;
	assign div_ctl.adv_b = ld4;

	salnt_recip_div #(.SUM_W(SUM_W), .DIVISOR(SAMPLE_WINDOW)) u_dust_div (
		.clk(clk), .ctl(div_ctl), .sum(dust_sum_s2), .quot(dust_avg_s4)
	);
	salnt_recip_div #(.SUM_W(SUM_W), .DIVISOR(SAMPLE_WINDOW)) u_light_div (
		.clk(clk), .ctl(div_ctl), .sum(light_sum_s2), .quot(light_avg_s4)
	);
	salnt_recip_div #(.SUM_W(PSUM_W), .DIVISOR(PEAK_WINDOW)) u_peak_div (
		.clk(clk), .ctl(div_ctl), .sum(peak_sum_s2), .quot(peak_avg_s4)
	);

	// held noise values
	logic [AVG_W-1:0] held_avg_q, noise_avg_n;
	logic             seen_q, seen_n;
	logic             adv45;

	assign adv45       = v4 && ld5;
	assign noise_avg_n = close_s4 ? peak_avg_s4 : held_avg_q;
	assign seen_n      = seen_q || close_s4;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			pos_q <= '0;
			pk_q <= '0;
			ring_vld_q <= '0;
			peak_vld_q <= '0;
			dust_sum_q <= '0;
			light_sum_q <= '0;
			peak_sum_q <= '0;
			held_avg_q <= '0;
			seen_q <= 1'b0;
		end else begin
			if (ld1) v1 <= sample_valid;
			if (ld2) v2 <= v1;
			if (ld3) v3 <= v2;
			if (ld4) v4 <= v3;
			if (ld5) v5 <= v4;
			if (accept) begin
				ring_vld_q[pos_q] <= 1'b1;
				pos_q <= close_n ? '0 : pos_q + POS_W'(1);
				if (close_n) begin
					peak_vld_q[pk_q] <= 1'b1;
					pk_q <= (pk_q == PK_W'(PEAK_WINDOW - 1)) ? '0 : pk_q + PK_W'(1);
				end
			end
			if (adv12) begin
				dust_sum_q  <= dust_sum_n;
				light_sum_q <= light_sum_n;
				if (close_s1) peak_sum_q <= peak_sum_n;
			end
			if (adv45) begin
				held_avg_q <= noise_avg_n;
				seen_q     <= seen_n;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_vld_s1 <= ring_vld_q[pos_q];
			peak_vld_s1 <= peak_vld_q[pk_q];
			dust_s1     <= sample.dust_sample;
			light_s1    <= sample.light_sample;
			pp_s1       <= pp_n;
			close_s1    <= close_n;
			wmax_q      <= wmax_n;
			wmin_q      <= wmin_n;
		end
		if (ld2) begin
			dust_sum_s2  <= dust_sum_n;
			light_sum_s2 <= light_sum_n;
			peak_sum_s2  <= peak_sum_n;
			close_s2     <= close_s1;
		end
		if (ld3) close_s3 <= close_s2;
		if (ld4) close_s4 <= close_s3;
		if (ld5) begin
			result.dust_average  <= dust_avg_s4;
			result.dust_level    <= level_of(dust_avg_s4, DUST_STEP);
			result.light_average <= light_avg_s4;
			result.light_level   <= level_of(light_avg_s4, LIGHT_STEP);
			result.noise_average <= noise_avg_n;
			result.noise_level   <= seen_n ? level_of(noise_avg_n, LIGHT_STEP) : '0;
			result.noise_updated <= close_s4;
		end
	end

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> v1)
		else $error("input stalled with stage 1 empty");

	a_update_has_level: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.noise_updated) |-> (result.noise_level != '0))
		else $error("window close without noise level");

	a_dust_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.dust_level >= LEVEL_W'(1) &&
			result.dust_level <= LEVEL_W'(LEVEL_TOP)))
		else $error("dust level out of range");

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seen_q))
		else $error("noise seen flag cleared");

endmodule

// ----- sim/tb_sensor_average_level_noise_tracker_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sensor_average_level_noise_tracker_core: directed and random
// sensor samples, with a behavioral tracker of the averages, levels and noise envelope.
// Depends on salnt_pkg and the core RTL.
module tb_sensor_average_level_noise_tracker_core;
	import salnt_pkg::*;

	localparam int SAMPLE_WINDOW  = 50;
	localparam int PEAK_WINDOW    = 10;
	localparam int DUST_CAP       = 799;
	localparam int LIGHT_CAP      = 999;
	localparam int ADC_MAX        = 1023;
	localparam int NOISE_HI_START = -1;
	localparam int NOISE_LO_START = 1025;
	localparam int RANDOM_ITEMS   = 900;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_AT_RESULT = 300;
	localparam int LONG_HOLD      = 300;
	localparam int IDLE_LIMIT     = 4000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_PRINTS     = 40;

	typedef enum logic [1:0] {
		SWING_FLAT,
		SWING_WIDE,
		SWING_FULL,
		SWING_NARROW
	} swing_shape_e;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample       = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	sample_t pending_samples[$];
	result_t predicted_results[$];

	// tracker state
	logic [AVG_W-1:0]   dust_hist [SAMPLE_WINDOW];
	logic [AVG_W-1:0]   light_hist [SAMPLE_WINDOW];
	logic [AVG_W-1:0]   swing_hist [PEAK_WINDOW];
	int                 dust_total, light_total, swing_total;
	int                 tick_pos, swing_pos;
	int                 noise_hi, noise_lo;
	logic [AVG_W-1:0]   held_avg;
	logic [LEVEL_W-1:0] held_lvl;

	// stimulus shaping
	int           seg_left [2];
	int           seg_mode [2];
	int           seg_base [2];
	swing_shape_e noise_shape = SWING_FULL;
	int           noise_base, noise_span;

	int mismatches, samples_sent, results_seen, total_items, idle_cycles;
	int send_gap, send_mode_left, recv_gap, recv_mode_left, hold_left;
	bit send_burst, recv_burst, hold_done;

	sensor_average_level_noise_tracker_core #(
		.SAMPLE_WINDOW(SAMPLE_WINDOW),
		.PEAK_WINDOW  (PEAK_WINDOW)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LEVEL_W-1:0] level_for(int avg, int cap, int step);
		if (avg > cap)
			return LEVEL_W'(LEVEL_TOP);
		return LEVEL_W'(avg / step + 1);
	endfunction

	task automatic clear_tracker();
		for (int k = 0; k < SAMPLE_WINDOW; k++) begin
			dust_hist[k]  = '0;
			light_hist[k] = '0;
		end
		for (int k = 0; k < PEAK_WINDOW; k++)
			swing_hist[k] = '0;
		dust_total  = 0;
		light_total = 0;
		swing_total = 0;
		tick_pos    = 0;
		swing_pos   = 0;
		noise_hi    = NOISE_HI_START;
		noise_lo    = NOISE_LO_START;
		held_avg    = '0;
		held_lvl    = '0;
	endtask

	task automatic track_sample(input sample_t s, output result_t r);
		int dust_avg, light_avg, swing;
		dust_total  = dust_total - int'(dust_hist[tick_pos]) + int'(s.dust_sample);
		light_total = light_total - int'(light_hist[tick_pos]) + int'(s.light_sample);
		dust_hist[tick_pos]  = s.dust_sample;
		light_hist[tick_pos] = s.light_sample;
		dust_avg  = dust_total / SAMPLE_WINDOW;
		light_avg = light_total / SAMPLE_WINDOW;
		if (int'(s.noise_sample) > noise_hi)
			noise_hi = int'(s.noise_sample);
		if (int'(s.noise_sample) < noise_lo)
			noise_lo = int'(s.noise_sample);
		r.noise_updated = 1'b0;
		tick_pos++;
		if (tick_pos == SAMPLE_WINDOW) begin
			// window closes: peak-to-peak enters the envelope ring, level is held
			swing = noise_hi - noise_lo;
			swing_total = swing_total - int'(swing_hist[swing_pos]) + swing;
			swing_hist[swing_pos] = AVG_W'(swing);
			held_avg = AVG_W'(swing_total / PEAK_WINDOW);
			held_lvl = level_for(int'(held_avg), LIGHT_CAP, int'(LIGHT_STEP));
			swing_pos = (swing_pos + 1 == PEAK_WINDOW) ? 0 : swing_pos + 1;
			tick_pos = 0;
			noise_hi = NOISE_HI_START;
			noise_lo = NOISE_LO_START;
			r.noise_updated = 1'b1;
		end
		r.dust_average  = AVG_W'(dust_avg);
		r.dust_level    = level_for(dust_avg, DUST_CAP, int'(DUST_STEP));
		r.light_average = AVG_W'(light_avg);
		r.light_level   = level_for(light_avg, LIGHT_CAP, int'(LIGHT_STEP));
		r.noise_average = held_avg;
		r.noise_level   = held_lvl;
	endtask

	task automatic add_sample(input int d, input int l, input int n);
		sample_t s;
		s.dust_sample  = AVG_W'(d);
		s.light_sample = AVG_W'(l);
		s.noise_sample = AVG_W'(n);
		pending_samples.push_back(s);
	endtask

	// values that sit on or next to a level boundary once a window is full of them, or at a rail, or random
	function automatic int boundary_value();
		int k, j;
		k = $urandom_range(1, 9);
		j = $urandom_range(0, 1);
		case ($urandom_range(0, 6))
			0: return 0;
			1: return ADC_MAX;
			2: return k * int'(DUST_STEP) - j;
			3: return k * int'(LIGHT_STEP) - j;
			4: return DUST_CAP + j;
			5: return LIGHT_CAP + j;
			default: return $urandom_range(0, ADC_MAX);
		endcase
	endfunction

	function automatic int next_reading(int ch);
		int v, j;
		if (seg_left[ch] == 0) begin
			seg_left[ch] = $urandom_range(10, 120);
			seg_mode[ch] = $urandom_range(0, 3);
			seg_base[ch] = boundary_value();
		end
		seg_left[ch]--;
		j = $urandom_range(0, 6);
		case (seg_mode[ch])
			0, 1: v = seg_base[ch];
			2: v = seg_base[ch] + j - 3;
			default: v = $urandom_range(0, ADC_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return v;
	endfunction

	function automatic int next_noise(int idx);
		int pos, w, v;
		pos = idx % SAMPLE_WINDOW;
		w   = idx / SAMPLE_WINDOW;
		if (pos == 0) begin
			// enough wide windows in a row to push the envelope level to the top
			if (w >= 1 && w <= PEAK_WINDOW + 1)
				noise_shape = SWING_WIDE;
			else
				noise_shape = swing_shape_e'($urandom_range(0, 3));
			noise_base = $urandom_range(0, ADC_MAX);
			noise_span = $urandom_range(0, 40);
		end
		case (noise_shape)
			SWING_FLAT: v = noise_base;
			SWING_WIDE: begin
				if (pos == 0)
					v = $urandom_range(0, 12);
				else if (pos == 1)
					v = $urandom_range(ADC_MAX - 12, ADC_MAX);
				else
					v = $urandom_range(12, ADC_MAX - 12);
			end
			SWING_FULL: v = $urandom_range(0, ADC_MAX);
			default: begin
				v = noise_base + $urandom_range(0, noise_span);
				if (v > ADC_MAX)
					v = ADC_MAX;
			end
		endcase
		return v;
	endfunction

	task automatic pick_gap(inout int mode_left, inout bit burst, output int gap);
		if (mode_left == 0) begin
			mode_left = $urandom_range(20, 80);
			burst = ($urandom_range(0, 3) == 0);
		end
		mode_left--;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin : drive_samples
		result_t predicted;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
			send_gap     = 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				track_sample(sample, predicted);
				predicted_results.push_back(predicted);
				samples_sent++;
			end
			if (!(sample_valid && sample_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					sample       <= pending_samples.pop_front();
					sample_valid <= 1'b1;
					pick_gap(send_mode_left, send_burst, send_gap);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin : check_results
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_gap     = 0;
			hold_left    = 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					report_mismatch("result with no sample outstanding");
				end else begin
					want = predicted_results.pop_front();
					check_field("dust_average", result.dust_average, want.dust_average);
					check_field("dust_level", result.dust_level, want.dust_level);
					check_field("light_average", result.light_average, want.light_average);
					check_field("light_level", result.light_level, want.light_level);
					check_field("noise_average", result.noise_average, want.noise_average);
					check_field("noise_level", result.noise_level, want.noise_level);
					check_field("noise_updated", result.noise_updated, want.noise_updated);
				end
				pick_gap(recv_mode_left, recv_burst, recv_gap);
				// one long back-pressure stretch so the core fills and stalls its input
				if (!hold_done && results_seen == HOLD_AT_RESULT) begin
					hold_left = LONG_HOLD;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("sensor_average_level_noise_tracker_core verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : run
		int idx;
		clear_tracker();

		// bit extremes, level boundaries, full-scale noise inside the first window
		add_sample(0, 0, 0);
		add_sample(ADC_MAX, ADC_MAX, ADC_MAX);
		add_sample('h2AA, 'h155, 'h2AA);
		add_sample('h155, 'h2AA, 'h155);
		add_sample(ADC_MAX, 0, 512);
		add_sample(0, ADC_MAX, 1);
		add_sample(79, 99, 0);
		add_sample(80, 100, ADC_MAX);
		add_sample(DUST_CAP, LIGHT_CAP, 300);
		add_sample(DUST_CAP + 1, LIGHT_CAP + 1, 700);
		add_sample(ADC_MAX, ADC_MAX, 0);
		add_sample(ADC_MAX, ADC_MAX, ADC_MAX);
		add_sample(ADC_MAX, ADC_MAX, 511);
		add_sample(ADC_MAX, ADC_MAX, 512);
		add_sample(0, 0, 1022);
		add_sample(1, 1, 2);
		add_sample(ADC_MAX, 0, ADC_MAX);
		add_sample(0, ADC_MAX, 0);

		total_items = pending_samples.size() + RANDOM_ITEMS;
		for (idx = pending_samples.size(); idx < total_items; idx++)
			add_sample(next_reading(0), next_reading(1), next_noise(idx));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (!(samples_sent == total_items && predicted_results.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("sensor_average_level_noise_tracker_core verification clean");
		else
			$display("sensor_average_level_noise_tracker_core verification failed");
		$finish;
	end

endmodule
